// ----- design/wwt_pkg.sv -----
// Package for the whitespace word tokenizer.
// Sizes, field types, sequencer states and shared constants. No dependencies.
package wwt_pkg;
	localparam int VocabEntries = 1024;
	localparam int EntryBytes   = 16;
	localparam int WordCap      = EntryBytes - 2;
	localparam int EntW  = $clog2(VocabEntries);
	localparam int PosW  = $clog2(EntryBytes);
	localparam int LenW  = $clog2(WordCap + 1);
	localparam int CntW  = $clog2(VocabEntries + 1);
	localparam int EntryBits = EntryBytes * 8;

	localparam logic [7:0] SpaceChar = 8'd32;
	localparam logic [7:0] NullChar  = 8'd0;
	localparam logic [9:0] StartTok  = 10'd1;
	localparam logic [9:0] UnknownTok = 10'd0;
	localparam logic [EntW-1:0] FirstWord = EntW'(3);

	localparam logic       CfgVocab = 1'b0;
	localparam logic       ActLoad  = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RD, ST_CMP, ST_OUT1, ST_OUT2
	} state_t;

	typedef struct packed {
		logic [9:0] id;
		logic       valid;
		logic       done;
	} result_t;

	typedef struct packed {
		logic start;
		logic done;
		logic hit;
		logic [EntW-1:0] index;
	} scan_ctl_t;
endpackage

// ----- design/wwt_vocab_ram.sv -----
// Byte-banked vocabulary table: one byte written, one whole entry read per cycle.
// Depends on wwt_pkg.
module wwt_vocab_ram (
	input  logic clk,
	input  logic wr_en,
	input  logic [wwt_pkg::EntW-1:0] wr_entry,
	input  logic [wwt_pkg::PosW-1:0] wr_pos,
	input  logic [7:0] wr_data,
	input  logic [wwt_pkg::EntW-1:0] rd_entry,
	output logic [wwt_pkg::EntryBits-1:0] rd_data
);
	import wwt_pkg::*;
	for (genvar b = 0; b < EntryBytes; b++) begin : g_bank
		logic [7:0] mem [VocabEntries];
		logic [7:0] rd_q;
		always_ff @(posedge clk) begin
			if (wr_en && wr_pos == PosW'(b)) begin
				mem[wr_entry] <= wr_data;
			end
			rd_q <= mem[rd_entry];
		end
		assign rd_data[b*8 +: 8] = rd_q;
	end
endmodule

// ----- design/wwt_matcher.sv -----
// Shared entry comparator and scan sequencer: one entry tested per cycle.
// Depends on wwt_pkg and wwt_vocab_ram read data.
module wwt_matcher (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [wwt_pkg::CntW-1:0] limit,
	input  logic [wwt_pkg::EntryBits-1:0] rd_data,
	input  logic [wwt_pkg::WordCap*8-1:0] word,
	input  logic [wwt_pkg::LenW-1:0] len,
	output logic [wwt_pkg::EntW-1:0] rd_entry,
	output wwt_pkg::scan_ctl_t ctl
);
	import wwt_pkg::*;
	logic [CntW-1:0] addr_q, cmp_q;
	logic busy_q, pend_q, done_q, hit_q;
	logic [EntW-1:0] idx_q;
	logic match;

	assign rd_entry = addr_q[EntW-1:0];

	always_comb begin
		match = (rd_data[7:0] == SpaceChar);
		for (int b = 1; b < EntryBytes; b++) begin
			if (b - 1 < int'(len)) begin
				if (rd_data[b*8 +: 8] != word[(b-1)*8 +: 8]) match = 1'b0;
			end else if (b - 1 == int'(len)) begin
				if (rd_data[b*8 +: 8] != NullChar) match = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; pend_q <= 1'b0; done_q <= 1'b0; hit_q <= 1'b0;
			addr_q <= '0; cmp_q <= '0; idx_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				addr_q <= CntW'(FirstWord);
				busy_q <= 1'b1; pend_q <= 1'b0; hit_q <= 1'b0;
			end else if (busy_q) begin
				if (pend_q && match) begin
					busy_q <= 1'b0; done_q <= 1'b1; hit_q <= 1'b1;
					idx_q <= cmp_q[EntW-1:0];
				end else if (addr_q >= limit) begin
					if (!pend_q) begin
						busy_q <= 1'b0; done_q <= 1'b1; hit_q <= 1'b0;
					end
					pend_q <= 1'b0;
				end else begin
					cmp_q <= addr_q;
					pend_q <= 1'b1;
					addr_q <= addr_q + 1'b1;
				end
			end
		end
	end

	assign ctl.start = start;
	assign ctl.done  = done_q;
	assign ctl.hit   = hit_q;
	assign ctl.index = idx_q;
endmodule

// ----- design/whitespace_word_tokenizer.sv -----
// Whitespace word tokenizer, top level: prompt control, word buffer, output queue.
// Depends on wwt_pkg, wwt_vocab_ram and wwt_matcher.
// Load items write one table byte; scanless text items go from ST_RD to the output states.
// A flush scans entries 3 to min(vocab_count,1024)-1 one per cycle until the first hit.
// Results wait in a two-entry output queue; input is held off until it drains.
// arst_n clears control state; the vocabulary table is undefined until written.
module whitespace_word_tokenizer (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [10:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [23:0] s_tdata,  // action, entry_index, byte_position, char_value
	input  logic s_tlast,         // end_of_prompt
	output logic m_tvalid,
	input  logic m_tready,
	output logic [15:0] m_tdata,  // token_id, token_valid
	output logic m_tlast          // prompt_done
);
	import wwt_pkg::*;
	state_t st_q, st_d;
	logic [10:0] vcount_q;
	logic [8:0] maxtok_q, emitted_q;
	logic [LenW-1:0] len_q;
	logic ovf_q, started_q;
	logic [WordCap*8-1:0] word_q;
	result_t r0_q, r1_q;
	logic [1:0] nres_q;
	logic eop_q, flush_q;
	logic [EntW-1:0] rd_entry;
	logic [EntryBits-1:0] rd_data;
	scan_ctl_t sc;
	logic scan_go;
	logic [CntW-1:0] limit;

	logic act;
	logic [9:0] in_ent;
	logic [3:0] in_pos;
	logic [7:0] in_chr;
	assign act = s_tdata[0];
	assign in_ent = s_tdata[10:1];
	assign in_pos = s_tdata[14:11];
	assign in_chr = s_tdata[22:15];

	wire acc = s_tvalid && s_tready;
	assign s_tready = (st_q == ST_IDLE);
	assign limit = (vcount_q > 11'(VocabEntries)) ? CntW'(VocabEntries) : CntW'(vcount_q);

	wwt_vocab_ram u_ram (.clk, .wr_en(acc && act == ActLoad), .wr_entry(in_ent),
		.wr_pos(in_pos), .wr_data(in_chr), .rd_entry, .rd_data);
	wwt_matcher u_match (.clk, .arst_n, .start(scan_go), .limit, .rd_data,
		.word(word_q), .len(len_q), .rd_entry, .ctl(sc));

	wire pending = (len_q != '0) || ovf_q;
	wire can_emit = emitted_q < maxtok_q;
	assign scan_go = (st_q == ST_RD) && flush_q && pending && can_emit && !ovf_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (acc && act != ActLoad) st_d = ST_RD;
			ST_RD:   st_d = scan_go ? ST_CMP : ST_OUT1;
			ST_CMP:  if (sc.done) st_d = ST_OUT1;
			ST_OUT1: if (nres_q == 2'd0) st_d = ST_IDLE; else st_d = ST_OUT2;
			ST_OUT2: if (nres_q == 2'd0) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; vcount_q <= '0; maxtok_q <= 9'd200; emitted_q <= '0;
			len_q <= '0; ovf_q <= 1'b0; started_q <= 1'b0; nres_q <= '0;
			eop_q <= 1'b0; flush_q <= 1'b0; r0_q <= '0; r1_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_index == CfgVocab) vcount_q <= cfg_data;
				else maxtok_q <= cfg_data[8:0];
			end
			if (m_tvalid && m_tready) begin
				r0_q <= r1_q;
				nres_q <= nres_q - 2'd1;
			end
			if (st_q == ST_IDLE && acc && act != ActLoad) begin
				eop_q <= s_tlast;
				flush_q <= (in_chr == SpaceChar) || s_tlast;
				if (!started_q) begin
					r0_q <= '{id: StartTok, valid: 1'b1, done: 1'b0};
					nres_q <= 2'd1;
					started_q <= 1'b1;
					emitted_q <= 9'd1;
				end
				if (in_chr != SpaceChar && in_chr != NullChar) begin
					if (len_q < LenW'(WordCap)) begin
						word_q[len_q*8 +: 8] <= in_chr;
						len_q <= len_q + 1'b1;
					end else ovf_q <= 1'b1;
				end
			end
			if ((st_q == ST_RD && !scan_go) || (st_q == ST_CMP && sc.done)) begin
				if (st_q == ST_CMP || (flush_q && pending && can_emit)) begin
					if (nres_q == 2'd0)
						r0_q <= '{id: sc.done && sc.hit ? 10'(sc.index) : UnknownTok,
							valid: 1'b1, done: eop_q};
					else
						r1_q <= '{id: sc.done && sc.hit ? 10'(sc.index) : UnknownTok,
							valid: 1'b1, done: eop_q};
					nres_q <= nres_q + 2'd1;
					if (!eop_q) emitted_q <= emitted_q + 9'd1;
				end else if (eop_q) begin
					if (nres_q == 2'd0) begin
						r0_q <= '{id: UnknownTok, valid: 1'b0, done: 1'b1};
						nres_q <= 2'd1;
					end else r0_q.done <= 1'b1;
				end
				if (flush_q) begin
					len_q <= '0; ovf_q <= 1'b0;
				end
				if (eop_q) begin
					started_q <= 1'b0; emitted_q <= '0;
				end
			end
		end
	end

	assign m_tvalid = (nres_q != 2'd0) && (st_q == ST_OUT1 || st_q == ST_OUT2);
	assign m_tdata = {5'd0, r0_q.valid, r0_q.id};
	assign m_tlast = r0_q.done;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid) else $error("input taken with results pending");
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CMP) |-> !s_tready) else $error("ready during scan");
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		nres_q <= 2'd2) else $error("output queue overflow");
endmodule
